[rtl/dfp_pkg.sv]
`default_nettype none

package dfp_pkg;

    // Packed BCD result word
    localparam int unsigned DIGIT_BITS      = 4;
    localparam int unsigned DIGITS_PER_WORD = 16;
    localparam int unsigned WORD_BITS       = DIGIT_BITS * DIGITS_PER_WORD;
    localparam int unsigned MAX_WORDS       = 32;
    localparam int unsigned COUNT_BITS      = 10;

    // Operand widths
    localparam int unsigned FACTOR_BITS = 8;
    localparam int unsigned CARRY_BITS  = 8;   // carry never exceeds 255
    localparam int unsigned PROD_BITS   = 12;  // digit * factor + carry <= 2550

    // Divide by ten: q = (p * 3277) >> 15, exact for p below 16384
    localparam logic [PROD_BITS-1:0] RECIP_TEN   = 12'd3277;
    localparam int unsigned          RECIP_SHIFT = 15;

    localparam logic [DIGIT_BITS-1:0] DIGIT_ZERO = 4'd0;
    localparam logic [DIGIT_BITS-1:0] DIGIT_ONE  = 4'd1;
    localparam logic [DIGIT_BITS-1:0] DIGIT_NINE = 4'd9;

    // Operation codes
    localparam logic OP_FACTORIAL   = 1'b0;
    localparam logic OP_PERMUTATION = 1'b1;

endpackage

`default_nettype wire

[rtl/dfp_ram.sv]
`default_nettype none

module dfp_ram #(
    parameter int unsigned WIDTH = 4,
    parameter int unsigned DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/decimal_factorial_permutation.sv]
`default_nettype none

// For each factor, S_RD reads digit 0, then every stored digit passes through the shared
//   multiply/divide-by-ten unit (S_MP, S_DV) and is written back. S_PREP then sets up the
//   output and the digits are read out through the single digit-store read port, most
//   significant word first; S_TAIL drains, and the last word strobes in the cycle busy drops.
//   One request at a time; busy stays high meanwhile.
// Results come out as one-cycle o_valid strobes; the receiver cannot stall them.
// Reset (i_rst_n low, synchronous) returns to idle; the digit store is not cleared.
module decimal_factorial_permutation #(
    parameter int unsigned MAX_DIGITS = 512
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                i_operation,
    input  wire logic [dfp_pkg::FACTOR_BITS-1:0]     i_n,
    input  wire logic [dfp_pkg::FACTOR_BITS-1:0]     i_r,
    output logic                                     o_valid,
    output logic      [dfp_pkg::WORD_BITS-1:0]       o_digit_word,
    output logic                                     o_last,
    output logic      [dfp_pkg::COUNT_BITS-1:0]      o_digit_count,
    output logic                                     o_overflow
);
    import dfp_pkg::*;

    // Digit address and digit length widths follow the store depth
    localparam int unsigned IW = $clog2(MAX_DIGITS);
    localparam int unsigned LW = $clog2(MAX_DIGITS + 1);

    typedef enum logic [2:0] {
        S_IDLE,   // wait for a request
        S_RD,     // issue the read of digit 0 for a new factor
        S_MP,     // digit * factor + carry
        S_DV,     // split into new digit and carry, write back
        S_PREP,   // set up the word counter for output
        S_EM,     // read digits out, most significant word first
        S_TAIL    // let the last digit land in the output word
    } t_state;

    t_state                  r_state;
    logic [FACTOR_BITS-1:0]  r_n;
    logic [FACTOR_BITS-1:0]  r_f;
    logic [CARRY_BITS-1:0]   r_carry;
    logic [PROD_BITS-1:0]    r_p;
    logic [IW-1:0]           r_idx;
    logic [LW-1:0]           r_len;
    logic                    r_ext;
    logic                    r_ovf;

    // Output gather
    logic [4:0]              r_word;
    logic [3:0]              r_dig;
    logic                    r_pv;
    logic                    r_pok;
    logic                    r_plast;
    logic                    r_pfinal;
    logic [WORD_BITS-1:0]    r_acc;

    logic                    r_out_valid;
    logic [WORD_BITS-1:0]    r_out_word;
    logic                    r_out_last;
    logic [COUNT_BITS-1:0]   r_out_count;
    logic                    r_out_ovf;

    // Store port
    logic                    ram_we;
    logic [IW-1:0]           ram_waddr;
    logic [DIGIT_BITS-1:0]   ram_wdata;
    logic [IW-1:0]           ram_raddr;
    logic [DIGIT_BITS-1:0]   ram_rdata;

    // Request decode
    logic                    accept;
    logic                    zero_res;
    logic [8:0]              lo_f;
    logic                    empty_prod;

    // Shared arithmetic
    logic [DIGIT_BITS-1:0]   mul_digit;
    logic [PROD_BITS-1:0]    n_p;
    logic [2*PROD_BITS-1:0]  q_full;
    logic [CARRY_BITS-1:0]   q;
    logic [PROD_BITS-1:0]    q_ten;
    logic [PROD_BITS-1:0]    rem_full;
    logic [DIGIT_BITS-1:0]   rem;
    logic                    last_pos;
    logic                    store_full;

    // Output helpers
    logic [8:0]              pos;
    logic [15:0]             len_m1;
    logic [4:0]              word_top;
    logic [DIGIT_BITS-1:0]   emit_digit;
    logic [WORD_BITS-1:0]    n_acc;

    assign accept     = start && !busy;
    assign zero_res   = (i_operation == OP_PERMUTATION) && (i_r > i_n);
    assign lo_f       = (i_operation == OP_PERMUTATION) ?
                        ({1'b0, i_n} - {1'b0, i_r} + 9'd1) : 9'd2;
    assign empty_prod = lo_f > {1'b0, i_n};

    // One digit step: the product is registered before the reciprocal multiply
    assign mul_digit  = r_ext ? DIGIT_ZERO : ram_rdata;
    assign n_p        = PROD_BITS'(mul_digit) * PROD_BITS'(r_f) + PROD_BITS'(r_carry);
    assign q_full     = (2*PROD_BITS)'(r_p) * (2*PROD_BITS)'(RECIP_TEN);
    assign q          = q_full[RECIP_SHIFT +: CARRY_BITS];
    assign q_ten      = PROD_BITS'({q, 3'b000}) + PROD_BITS'({q, 1'b0});
    assign rem_full   = r_p - q_ten;
    assign rem        = rem_full[DIGIT_BITS-1:0];
    assign last_pos   = (LW'(r_idx) + LW'(1)) == r_len;
    assign store_full = r_len == LW'(MAX_DIGITS);

    // Output word addressing
    assign pos        = {r_word, r_dig};
    assign len_m1     = 16'(r_len) - 16'd1;
    assign word_top   = (len_m1[15:4] > 12'(MAX_WORDS - 1)) ? 5'(MAX_WORDS - 1) : len_m1[8:4];
    assign emit_digit = r_pok ? (r_ovf ? DIGIT_NINE : ram_rdata) : DIGIT_ZERO;
    assign n_acc      = {r_acc[WORD_BITS-DIGIT_BITS-1:0], emit_digit};

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = rem;
        ram_raddr = '0;
        case (r_state)
            S_IDLE: begin
                ram_we    = accept;
                ram_wdata = zero_res ? DIGIT_ZERO : DIGIT_ONE;
            end
            S_DV: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_raddr = r_idx + IW'(1);
            end
            S_EM: begin
                ram_raddr = IW'(pos);
            end
            default: begin
                ram_raddr = '0;
            end
        endcase
    end

    dfp_ram #(
        .WIDTH (DIGIT_BITS),
        .DEPTH (MAX_DIGITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= LW'(1);
            r_carry     <= '0;
            r_f         <= '0;
            r_ovf       <= 1'b0;
            r_ext       <= 1'b0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Gather pipeline: read data lands in the cycle after the address
            r_pv        <= (r_state == S_EM);
            r_out_valid <= r_pv && r_plast;
            if (r_pv) begin
                r_acc <= n_acc;
                if (r_plast) begin
                    r_out_word  <= n_acc;
                    r_out_last  <= r_pfinal;
                    r_out_count <= COUNT_BITS'(r_len);
                    r_out_ovf   <= r_ovf;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_n     <= i_n;
                        r_f     <= lo_f[FACTOR_BITS-1:0];
                        r_len   <= LW'(1);
                        r_carry <= '0;
                        r_idx   <= '0;
                        r_ext   <= 1'b0;
                        r_ovf   <= 1'b0;
                        r_state <= (zero_res || empty_prod) ? S_PREP : S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_MP;
                end
                S_MP: begin
                    r_p     <= n_p;
                    r_state <= S_DV;
                end
                S_DV: begin
                    // carry is zero whenever the factor loop moves on
                    r_carry <= q;
                    if (!last_pos) begin
                        // advance to the next stored digit
                        r_idx   <= r_idx + IW'(1);
                        r_state <= S_MP;
                    end else if (q != '0) begin
                        if (store_full) begin
                            // saturate: output reads as all nines
                            r_ovf   <= 1'b1;
                            r_state <= S_PREP;
                        end else begin
                            r_len   <= r_len + LW'(1);
                            r_idx   <= r_idx + IW'(1);
                            r_ext   <= 1'b1;
                            r_state <= S_MP;
                        end
                    end else if (r_f == r_n) begin
                        r_state <= S_PREP;
                    end else begin
                        r_f     <= r_f + FACTOR_BITS'(1);
                        r_idx   <= '0;
                        r_ext   <= 1'b0;
                        r_state <= S_RD;
                    end
                end
                S_PREP: begin
                    r_word  <= word_top;
                    r_dig   <= 4'(DIGITS_PER_WORD - 1);
                    r_state <= S_EM;
                end
                S_EM: begin
                    r_pok    <= 16'(pos) < 16'(r_len);
                    r_plast  <= (r_dig == '0);
                    r_pfinal <= (r_dig == '0) && (r_word == '0);
                    r_dig    <= r_dig - 4'd1;
                    if (r_dig == '0) begin
                        r_word <= r_word - 5'd1;
                        if (r_word == '0) begin
                            r_state <= S_TAIL;
                        end
                    end
                end
                S_TAIL: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_digit_word  = r_out_word;
    assign o_last        = r_out_last;
    assign o_digit_count = r_out_count;
    assign o_overflow    = r_out_ovf;

    // Length stays within the store
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len != '0) && (r_len <= LW'(MAX_DIGITS)))
        else $error("digit length out of range");

    // Saturated results carry the full store length
    a_ovf_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> (o_digit_count == COUNT_BITS'(MAX_DIGITS)))
        else $error("overflow result with wrong digit count");

    // An accepted request holds the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // The last word of a result is not directly followed by another word
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("word emitted after last");

endmodule

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import dfp_pkg::*;

    // Store depth of the block under test; the predictor uses the same limit.
    localparam int unsigned STORE_DIGITS = 512;
    // Largest digit count a product word can carry.
    localparam int unsigned WORD_MASK_DIGITS = DIGITS_PER_WORD;
    // Hard stop, well above the slowest legal run of this stimulus.
    localparam longint unsigned RUN_LIMIT_NS = 64'd200_000_000;
    // Settle time after the last word before the verdict.
    localparam int unsigned DRAIN_CYCLES = 100;
    localparam int unsigned RANDOM_REQUESTS = 78;
    localparam int unsigned DIRECTED_COUNT = 22;
    localparam int unsigned REPORT_LIMIT = 10;

    // Row kinds in the directed table
    localparam logic TYPED     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    // One expected output word
    typedef struct packed {
        logic [WORD_BITS-1:0]  word;
        logic                  last;
        logic [COUNT_BITS-1:0] count;
        logic                  ovf;
    } t_bcd_word;

    // One directed request, with its answer where it is plain to see
    typedef struct packed {
        logic                   op;
        logic [FACTOR_BITS-1:0] n;
        logic [FACTOR_BITS-1:0] r;
        logic                   kind;
        logic [WORD_BITS-1:0]   word;
        logic [COUNT_BITS-1:0]  count;
    } t_directed_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic                   i_operation = OP_FACTORIAL;
    logic [FACTOR_BITS-1:0] i_n = '0;
    logic [FACTOR_BITS-1:0] i_r = '0;
    logic                   o_valid;
    logic [WORD_BITS-1:0]   o_digit_word;
    logic                   o_last;
    logic [COUNT_BITS-1:0]  o_digit_count;
    logic                   o_overflow;

    decimal_factorial_permutation #(
        .MAX_DIGITS(STORE_DIGITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_operation  (i_operation),
        .i_n          (i_n),
        .i_r          (i_r),
        .o_valid      (o_valid),
        .o_digit_word (o_digit_word),
        .o_last       (o_last),
        .o_digit_count(o_digit_count),
        .o_overflow   (o_overflow)
    );

    // Directed requests: empty products, the r-above-n zero, field extremes,
    // word-boundary lengths (16 and 18 digits) and the full 32-word product.
    t_directed_row directed_rows [DIRECTED_COUNT] = '{
        '{OP_FACTORIAL,   8'd0,   8'd0,   TYPED,     64'h1,       10'd1},
        '{OP_FACTORIAL,   8'd1,   8'd255, TYPED,     64'h1,       10'd1},
        '{OP_FACTORIAL,   8'd2,   8'd0,   TYPED,     64'h2,       10'd1},
        '{OP_FACTORIAL,   8'd5,   8'd170, TYPED,     64'h120,     10'd3},
        '{OP_FACTORIAL,   8'd10,  8'd85,  TYPED,     64'h3628800, 10'd7},
        '{OP_FACTORIAL,   8'd18,  8'd0,   PREDICTED, 64'h0,       10'd0},
        '{OP_FACTORIAL,   8'd19,  8'd0,   PREDICTED, 64'h0,       10'd0},
        '{OP_FACTORIAL,   8'd25,  8'd0,   PREDICTED, 64'h0,       10'd0},
        '{OP_FACTORIAL,   8'd60,  8'd0,   PREDICTED, 64'h0,       10'd0},
        '{OP_PERMUTATION, 8'd0,   8'd0,   TYPED,     64'h1,       10'd1},
        '{OP_PERMUTATION, 8'd255, 8'd0,   TYPED,     64'h1,       10'd1},
        '{OP_PERMUTATION, 8'd1,   8'd1,   TYPED,     64'h1,       10'd1},
        '{OP_PERMUTATION, 8'd0,   8'd1,   TYPED,     64'h0,       10'd1},
        '{OP_PERMUTATION, 8'd0,   8'd255, TYPED,     64'h0,       10'd1},
        '{OP_PERMUTATION, 8'd254, 8'd255, TYPED,     64'h0,       10'd1},
        '{OP_PERMUTATION, 8'd10,  8'd3,   TYPED,     64'h720,     10'd3},
        '{OP_PERMUTATION, 8'd7,   8'd7,   TYPED,     64'h5040,    10'd4},
        '{OP_PERMUTATION, 8'd255, 8'd1,   TYPED,     64'h255,     10'd3},
        '{OP_PERMUTATION, 8'd255, 8'd2,   TYPED,     64'h64770,   10'd5},
        '{OP_PERMUTATION, 8'd100, 8'd50,  PREDICTED, 64'h0,       10'd0},
        '{OP_PERMUTATION, 8'd128, 8'd127, PREDICTED, 64'h0,       10'd0},
        '{OP_PERMUTATION, 8'd255, 8'd255, PREDICTED, 64'h0,       10'd0}
    };

    // Shadow of the product store, least significant digit first
    logic [DIGIT_BITS-1:0]  prod_digits [STORE_DIGITS];
    int unsigned            prod_len;
    int unsigned            prod_carry;
    logic [FACTOR_BITS-1:0] prod_factor;

    t_bcd_word   pending_words [$];
    int unsigned mismatches = 0;
    int unsigned requests_sent = 0;
    int unsigned words_seen = 0;
    int unsigned products_seen = 0;
    int unsigned longest_product = 0;
    int unsigned burst_left = 1;
    bit          drain_next = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Multiply out one request and queue every word it should produce.
    function automatic void queue_product(input logic op, input logic [FACTOR_BITS-1:0] n,
                                          input logic [FACTOR_BITS-1:0] r);
        int unsigned lo;
        int unsigned f;
        int unsigned i;
        int unsigned j;
        int unsigned k;
        int unsigned p;
        int unsigned words;
        int unsigned base;
        logic        ovf;
        t_bcd_word   res;
        ovf = 1'b0;
        prod_digits[0] = DIGIT_ONE;
        prod_len = 1;
        prod_carry = 0;
        if (op == OP_PERMUTATION && r > n) begin
            prod_digits[0] = DIGIT_ZERO;
        end else begin
            lo = (op == OP_FACTORIAL) ? 2 : (n - r + 1);
            for (f = lo; f <= n && !ovf; f++) begin
                prod_factor = f[FACTOR_BITS-1:0];
                prod_carry = 0;
                for (i = 0; i < prod_len; i++) begin
                    p = prod_digits[i] * prod_factor + prod_carry;
                    prod_digits[i] = DIGIT_BITS'(p % 10);
                    prod_carry = p / 10;
                end
                // Grow the store while carry remains; saturate past its end.
                while (prod_carry != 0 && !ovf) begin
                    if (prod_len >= STORE_DIGITS) begin
                        ovf = 1'b1;
                    end else begin
                        prod_digits[prod_len] = DIGIT_BITS'(prod_carry % 10);
                        prod_carry = prod_carry / 10;
                        prod_len++;
                    end
                end
            end
        end
        if (ovf) begin
            for (i = 0; i < STORE_DIGITS; i++) prod_digits[i] = DIGIT_NINE;
            prod_len = STORE_DIGITS;
            prod_carry = 0;
        end
        words = (prod_len + WORD_MASK_DIGITS - 1) / WORD_MASK_DIGITS;
        if (words > MAX_WORDS) words = MAX_WORDS;
        // Most significant word first; the top word is zero-padded.
        for (k = 0; k < words; k++) begin
            base = (words - 1 - k) * WORD_MASK_DIGITS;
            res.word = '0;
            for (j = 0; j < WORD_MASK_DIGITS; j++) begin
                if (base + j < prod_len)
                    res.word[DIGIT_BITS*j +: DIGIT_BITS] = prod_digits[base + j];
            end
            res.last = (k + 1 == words);
            res.count = COUNT_BITS'(prod_len);
            res.ovf = ovf;
            pending_words.push_back(res);
        end
    endfunction

    // Present one request and hold it until the block takes it. Close the
    // burst afterwards if it has run out, optionally draining the block.
    task automatic issue_request(input logic op, input logic [FACTOR_BITS-1:0] n,
                                 input logic [FACTOR_BITS-1:0] r, input logic kind,
                                 input logic [WORD_BITS-1:0] word,
                                 input logic [COUNT_BITS-1:0] count);
        t_bcd_word res;
        start <= 1'b1;
        i_operation <= op;
        i_n <= n;
        i_r <= r;
        do @(posedge i_clk); while (busy);
        // Taken at this edge
        if (kind == TYPED) begin
            res.word = word;
            res.last = 1'b1;
            res.count = count;
            res.ovf = 1'b0;
            pending_words.push_back(res);
        end else begin
            queue_product(op, n, r);
        end
        requests_sent++;
        burst_left--;
        if (burst_left == 0) begin
            start <= 1'b0;
            if (drain_next) begin
                while (pending_words.size() != 0) @(posedge i_clk);
                drain_next = 1'b0;
            end
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(50, 600)) @(posedge i_clk);
            else
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 8);
        end
    endtask

    // Check every strobed word against the oldest expectation.
    always @(posedge i_clk) begin
        t_bcd_word want;
        if (i_rst_n && o_valid) begin
            words_seen++;
            if (o_last) products_seen++;
            if (o_digit_count > longest_product) longest_product = 32'(o_digit_count);
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected word %h last %b count %0d ovf %b",
                             o_digit_word, o_last, o_digit_count, o_overflow);
            end else begin
                want = pending_words.pop_front();
                if (o_digit_word !== want.word || o_last !== want.last ||
                    o_digit_count !== want.count || o_overflow !== want.ovf) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("mismatch: want %h last %b count %0d ovf %b, got %h last %b count %0d ovf %b",
                                 want.word, want.last, want.count, want.ovf,
                                 o_digit_word, o_last, o_digit_count, o_overflow);
                end
            end
        end
    end

    initial begin
        int unsigned idx;
        int unsigned pick;
        int unsigned medium_left;
        logic [FACTOR_BITS-1:0] n;
        logic [FACTOR_BITS-1:0] r;
        logic op;
        medium_left = 3;

        // Hold reset, then release it once.
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (idx = 0; idx < DIRECTED_COUNT; idx++) begin
            // Drain the block completely after the directed part.
            if (idx == DIRECTED_COUNT - 1) begin
                burst_left = 1;
                drain_next = 1'b1;
            end
            issue_request(directed_rows[idx].op, directed_rows[idx].n, directed_rows[idx].r,
                          directed_rows[idx].kind, directed_rows[idx].word,
                          directed_rows[idx].count);
        end

        // Random part: keep the products short so the run stays affordable,
        // with a few medium factorials and plenty of r-above-n zeros.
        for (idx = 0; idx < RANDOM_REQUESTS; idx++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                op = OP_FACTORIAL;
                n = FACTOR_BITS'($urandom_range(0, 40));
                r = FACTOR_BITS'($urandom_range(0, 255));
            end else if (pick < 75) begin
                op = OP_PERMUTATION;
                n = FACTOR_BITS'($urandom_range(0, 255));
                r = FACTOR_BITS'($urandom_range(0, (n < 30) ? n : 30));
            end else if (pick < 90) begin
                op = OP_PERMUTATION;
                n = FACTOR_BITS'($urandom_range(0, 254));
                r = FACTOR_BITS'($urandom_range(n + 1, 255));
            end else begin
                op = OP_FACTORIAL;
                r = FACTOR_BITS'($urandom_range(0, 255));
                if (medium_left != 0) begin
                    n = FACTOR_BITS'($urandom_range(41, 150));
                    medium_left--;
                end else begin
                    n = FACTOR_BITS'($urandom_range(0, 40));
                end
            end
            // Occasionally stop and let the block empty before moving on;
            // always do so after the final request.
            if (idx == RANDOM_REQUESTS - 1 || $urandom_range(0, 14) == 0) begin
                burst_left = 1;
                drain_next = 1'b1;
            end
            issue_request(op, n, r, PREDICTED, '0, '0);
        end

        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests (%0d directed, %0d random) gave %0d products in %0d words",
                 requests_sent, DIRECTED_COUNT, RANDOM_REQUESTS, products_seen, words_seen);
        $display("longest product %0d digits, %0d mismatches", longest_product, mismatches);
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Stop a hung run.
    initial begin
        #(RUN_LIMIT_NS);
        $display("timeout with %0d words outstanding", pending_words.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
